@@ src/spot_pkg.sv @@
// Shared types and constants for the shape pair overlap test.
package spot_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int TYPE_BITS      = 2;

	typedef enum logic [TYPE_BITS-1:0] {
		SHAPE_BOX   = 2'd0,
		SHAPE_LEFT  = 2'd1,
		SHAPE_RIGHT = 2'd2,
		SHAPE_OTHER = 2'd3
	} shape_type_t;

	typedef enum logic [1:0] {
		PAIR_NONE    = 2'd0,
		PAIR_BOX_BOX = 2'd1,
		PAIR_BOX_TRI = 2'd2
	} pair_kind_t;

	// control that travels down the pipe beside the data
	typedef struct packed {
		logic       valid;
		pair_kind_t kind;
		logic       box_hit;
	} spot_ctl_t;

endpackage

@@ src/shape_pair_overlap_test.sv @@
// Top level: overlap test for box / right-triangle shape pairs.
//
// Usage:
//   Slave side (s_*): one request per shape pair. s_tdata carries the
//   centres and sizes, s_tuser the two shape types. Master side (m_*): one
//   request per pair, in order, with the overlap flag in m_tdata[0].
//   Shape types: box, left-rising triangle, right-rising triangle, other.
//   Box/box is an extent test, box/triangle adds a hypotenuse test done by
//   cross multiplication; any other pairing reports no overlap.
// Pipeline: three register stages (prep, multiply, decide). m_tvalid
//   rises when an accepted request, having passed the prep and multiply
//   registers, is loaded into the decide register. The stage depth is set
//   by the two (COORD_BITS+1) x (COORD_BITS+3) products.
// Throughput: one request per cycle, sustained, while m_tready is high.
// Stall: each stage advances when it is empty or the one after it moves,
//   so bubbles close up and s_tready only drops once all three stages hold
//   requests behind a stalled output. Nothing is dropped or repeated.
// Reset: arst_n clears all valid bits at once; the pipe comes up empty and
//   s_tready is high right after reset is released.
module shape_pair_overlap_test import spot_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h (COORD_BITS each, low to high)
	input  logic [8*COORD_BITS-1:0]   s_tdata,
	// a_type [1:0], b_type [3:2]
	input  logic [2*TYPE_BITS-1:0]    s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// overlap [0], zero padding [7:1]
	output logic [7:0]                m_tdata
);

	localparam int N = COORD_BITS;

	spot_ctl_t                ctl_s1, ctl_s2;
	logic signed [N+2:0]      dx_s1, dy_s1;
	logic        [N-1:0]      tri_w_s1, tri_h_s1;
	logic signed [2*N+3:0]    lhs_s2, rhs_s2;
	logic                     valid_s3, overlap_s3;
	logic                     en1, en2, en3;

	// a stage may load when it is empty or its contents move on
	assign en3      = !valid_s3 || m_tready;
	assign en2      = !ctl_s2.valid || en3;
	assign en1      = !ctl_s1.valid || en2;
	assign s_tready = en1;

	spot_prep #(.COORD_BITS(COORD_BITS)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.in_valid (s_tvalid),
		.a_type   (shape_type_t'(s_tuser[TYPE_BITS-1:0])),
		.a_x      (s_tdata[1*N-1:0*N]),
		.a_y      (s_tdata[2*N-1:1*N]),
		.a_w      (s_tdata[3*N-1:2*N]),
		.a_h      (s_tdata[4*N-1:3*N]),
		.b_type   (shape_type_t'(s_tuser[2*TYPE_BITS-1:TYPE_BITS])),
		.b_x      (s_tdata[5*N-1:4*N]),
		.b_y      (s_tdata[6*N-1:5*N]),
		.b_w      (s_tdata[7*N-1:6*N]),
		.b_h      (s_tdata[8*N-1:7*N]),
		.ctl_s1   (ctl_s1),
		.dx_s1    (dx_s1),
		.dy_s1    (dy_s1),
		.tri_w_s1 (tri_w_s1),
		.tri_h_s1 (tri_h_s1)
	);

	spot_mul #(.COORD_BITS(COORD_BITS)) u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.ctl_s1   (ctl_s1),
		.dx_s1    (dx_s1),
		.dy_s1    (dy_s1),
		.tri_w_s1 (tri_w_s1),
		.tri_h_s1 (tri_h_s1),
		.ctl_s2   (ctl_s2),
		.lhs_s2   (lhs_s2),
		.rhs_s2   (rhs_s2)
	);

	spot_decide #(.COORD_BITS(COORD_BITS)) u_decide (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en3),
		.ctl_s2     (ctl_s2),
		.lhs_s2     (lhs_s2),
		.rhs_s2     (rhs_s2),
		.valid_s3   (valid_s3),
		.overlap_s3 (overlap_s3)
	);

	assign m_tvalid = valid_s3;
	assign m_tdata  = {7'b0000000, overlap_s3};

endmodule

@@ src/spot_prep.sv @@
// Stage 1: pair classification, box extent tests, hypotenuse offsets.
module spot_prep import spot_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  shape_type_t                   a_type,
	input  logic signed [COORD_BITS-1:0]  a_x,
	input  logic signed [COORD_BITS-1:0]  a_y,
	input  logic        [COORD_BITS-1:0]  a_w,
	input  logic        [COORD_BITS-1:0]  a_h,
	input  shape_type_t                   b_type,
	input  logic signed [COORD_BITS-1:0]  b_x,
	input  logic signed [COORD_BITS-1:0]  b_y,
	input  logic        [COORD_BITS-1:0]  b_w,
	input  logic        [COORD_BITS-1:0]  b_h,
	output spot_ctl_t                     ctl_s1,
	output logic signed [COORD_BITS+2:0]  dx_s1,
	output logic signed [COORD_BITS+2:0]  dy_s1,
	output logic        [COORD_BITS-1:0]  tri_w_s1,
	output logic        [COORD_BITS-1:0]  tri_h_s1
);

	localparam int EW = COORD_BITS + 3;

	logic signed [EW-1:0] ax2, ay2, bx2, by2;
	logic signed [EW-1:0] aw_e, ah_e, bw_e, bh_e;
	logic signed [EW-1:0] box_x2, box_y2, box_w, box_h, tri_x2, tri_y2;
	logic signed [EW-1:0] dx, dy;
	logic                 a_box, b_box, a_tri, b_tri, swap, tri_right, hit;
	pair_kind_t           kind;
	logic                 valid_q;
	pair_kind_t           kind_q;
	logic                 hit_q;

	assign ax2  = {{3{a_x[COORD_BITS-1]}}, a_x} <<< 1;
	assign ay2  = {{3{a_y[COORD_BITS-1]}}, a_y} <<< 1;
	assign bx2  = {{3{b_x[COORD_BITS-1]}}, b_x} <<< 1;
	assign by2  = {{3{b_y[COORD_BITS-1]}}, b_y} <<< 1;
	assign aw_e = {3'b000, a_w};
	assign ah_e = {3'b000, a_h};
	assign bw_e = {3'b000, b_w};
	assign bh_e = {3'b000, b_h};

	assign a_box = (a_type == SHAPE_BOX);
	assign b_box = (b_type == SHAPE_BOX);
	assign a_tri = (a_type == SHAPE_LEFT) || (a_type == SHAPE_RIGHT);
	assign b_tri = (b_type == SHAPE_LEFT) || (b_type == SHAPE_RIGHT);

	always_comb begin
		priority if (a_box && b_box) begin
			kind = PAIR_BOX_BOX;
		end else if ((a_box && b_tri) || (a_tri && b_box)) begin
			kind = PAIR_BOX_TRI;
		end else begin
			kind = PAIR_NONE;
		end
	end

	// touching edges count as overlap
	assign hit = !((ax2 - aw_e) > (bx2 + bw_e)) && !((bx2 - bw_e) > (ax2 + aw_e)) &&
		!((ay2 - ah_e) > (by2 + bh_e)) && !((by2 - bh_e) > (ay2 + ah_e));

	// triangle first: swap so the box side is always box_*
	assign swap      = a_tri;
	assign box_x2    = swap ? bx2  : ax2;
	assign box_y2    = swap ? by2  : ay2;
	assign box_w     = swap ? bw_e : aw_e;
	assign box_h     = swap ? bh_e : ah_e;
	assign tri_x2    = swap ? ax2  : bx2;
	assign tri_y2    = swap ? ay2  : by2;
	assign tri_right = swap ? (a_type == SHAPE_RIGHT) : (b_type == SHAPE_RIGHT);

	// left triangle: dx is negated, i.e. s*dx
	assign dx = tri_right ? (box_x2 + box_w - tri_x2) : (tri_x2 + box_w - box_x2);
	assign dy = box_y2 - box_h - tri_y2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			kind_q   <= kind;
			hit_q    <= hit;
			dx_s1    <= dx;
			dy_s1    <= dy;
			tri_w_s1 <= swap ? a_w : b_w;
			tri_h_s1 <= swap ? a_h : b_h;
		end
	end

	assign ctl_s1 = '{valid: valid_q, kind: kind_q, box_hit: hit_q};

endmodule

@@ src/spot_mul.sv @@
// Stage 2: the two cross products of the hypotenuse test.
module spot_mul import spot_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  spot_ctl_t                     ctl_s1,
	input  logic signed [COORD_BITS+2:0]  dx_s1,
	input  logic signed [COORD_BITS+2:0]  dy_s1,
	input  logic        [COORD_BITS-1:0]  tri_w_s1,
	input  logic        [COORD_BITS-1:0]  tri_h_s1,
	output spot_ctl_t                     ctl_s2,
	output logic signed [2*COORD_BITS+3:0] lhs_s2,
	output logic signed [2*COORD_BITS+3:0] rhs_s2
);

	localparam int PW = 2 * COORD_BITS + 4;

	logic signed [PW-1:0] lhs, rhs;
	logic                 valid_q;
	pair_kind_t           kind_q;
	logic                 hit_q;

	// sizes are unsigned: a zero sign bit keeps the product signed
	assign lhs = $signed({1'b0, tri_h_s1}) * dx_s1;
	assign rhs = $signed({1'b0, tri_w_s1}) * dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctl_s1.valid) begin
			kind_q <= ctl_s1.kind;
			hit_q  <= ctl_s1.box_hit;
			lhs_s2 <= lhs;
			rhs_s2 <= rhs;
		end
	end

	assign ctl_s2 = '{valid: valid_q, kind: kind_q, box_hit: hit_q};

endmodule

@@ src/spot_decide.sv @@
// Stage 3: final verdict into the output register.
module spot_decide import spot_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  spot_ctl_t                      ctl_s2,
	input  logic signed [2*COORD_BITS+3:0] lhs_s2,
	input  logic signed [2*COORD_BITS+3:0] rhs_s2,
	output logic                           valid_s3,
	output logic                           overlap_s3
);

	logic overlap;

	always_comb begin
		unique case (ctl_s2.kind)
			PAIR_BOX_BOX: overlap = ctl_s2.box_hit;
			PAIR_BOX_TRI: overlap = ctl_s2.box_hit && !(lhs_s2 < rhs_s2);
			default:      overlap = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctl_s2.valid) begin
			overlap_s3 <= overlap;
		end
	end

endmodule

@@ src/spot_checker.sv @@
// Port-level checks for the shape pair overlap test, bound to the top level.
module spot_checker import spot_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_tvalid,
	input logic                    s_tready,
	input logic [2*TYPE_BITS-1:0]  s_tuser,
	input logic                    m_tvalid,
	input logic                    m_tready,
	input logic [7:0]              m_tdata
);

	logic other_in;

	assign other_in = (s_tuser[TYPE_BITS-1:0] == SHAPE_OTHER) ||
		(s_tuser[2*TYPE_BITS-1:TYPE_BITS] == SHAPE_OTHER);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an empty output stage means the whole pipe can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with output stage empty");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:1] == 7'b0000000))
		else $error("padding bits set");

	// a pair with an unsupported shape reports no overlap when m_tready stays high while it passes
	a_other: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && other_in) ##1 m_tready ##1 m_tready
		|=> m_tvalid && !m_tdata[0])
		else $error("unsupported pair reported overlap");

endmodule

bind shape_pair_overlap_test spot_checker u_spot_checker (.*);
